>>> rtl/trajectory_pair_distance_graph_defines.svh
// Assertion macros used by the pair engine of the trajectory pair distance graph RTL.
`ifndef TRAJECTORY_PAIR_DISTANCE_GRAPH_DEFINES_SVH
`define TRAJECTORY_PAIR_DISTANCE_GRAPH_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define TPDG_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define TPDG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/tpdg_pkg.sv
// Package: constants, types and codes of the trajectory pair distance graph.
`default_nettype none
package tpdg_pkg;

    localparam int TRACK_POINTS  = 15;
    localparam int WINDOW_TRACKS = 32;

    localparam int FRAME_W    = 16;
    localparam int COORD_W    = 16;
    localparam int POINT_W    = 2 * COORD_W;
    localparam int ID_W       = 20;
    localparam int WEIGHT_W   = 32;
    localparam int GAMMA_W    = 16;
    localparam int THR_W      = 16;
    localparam int OVL_W      = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 5;
    localparam int CNT_SAT    = (TRACK_POINTS + 1 > 31) ? 31 : TRACK_POINTS + 1;

    localparam int SLOT_W     = $clog2(WINDOW_TRACKS);
    localparam int ROWS       = WINDOW_TRACKS + 4;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int IDX_W      = $clog2(TRACK_POINTS);
    localparam int ADDR_W     = ROW_W + IDX_W;
    localparam int RAM_DEPTH  = ROWS * (2 ** IDX_W);

    localparam int FREE_DEPTH = 4;
    localparam int FREE_PW    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int SQ_W       = 2 * COORD_W;
    localparam int RAD_W      = 34;
    localparam int ROOT_W     = 17;
    localparam int ROOT_STEPS = 17;
    localparam int STEP_W     = 5;
    localparam int REM_W      = 21;
    localparam int SUM_W      = 22;
    localparam int LIM_W      = THR_W + OVL_W;
    localparam int OG_W       = IDX_W + GAMMA_W;
    localparam int PSQ_W      = 2 * OG_W;
    localparam int PEN_SHIFT  = 12;
    localparam int PEN_ROUND  = 2048;
    localparam int WFULL_W    = 48;

    typedef enum logic [1:0] {
        CFG_GAMMA   = 2'd0,
        CFG_SPATIAL = 2'd1,
        CFG_OVERLAP = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_TRACK = 1'b0,
        CMD_DROP  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [FRAME_W-1:0] end_frame;
        logic [ROW_W-1:0]   row;
    } cmd_t;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } rel_t;

    typedef struct packed {
        logic [GAMMA_W-1:0] gamma;
        logic [THR_W-1:0]   spatial_threshold;
        logic [OVL_W-1:0]   overlap_threshold;
    } cfg_t;

    typedef enum logic [3:0] {
        B_IDLE, B_SLOT, B_RD, B_SQ, B_INIT, B_ROOT, B_ACC,
        B_CMP, B_PEN, B_EDGE, B_NEXT, B_FIN, B_LAST
    } back_state_t;

endpackage
`default_nettype wire

>>> rtl/tpdg_if.sv
// Interfaces: point input channel and edge output channel.
`default_nettype none
interface tpdg_point_if;
    logic                          valid;
    logic                          ready;
    logic [tpdg_pkg::FRAME_W-1:0]  end_frame;
    logic [tpdg_pkg::COORD_W-1:0]  x_coord;
    logic [tpdg_pkg::COORD_W-1:0]  y_coord;
    logic                          last_point;

    modport source (output valid, end_frame, x_coord, y_coord, last_point, input ready);
    modport sink   (input valid, end_frame, x_coord, y_coord, last_point, output ready);
endinterface

interface tpdg_edge_if;
    logic                          valid;
    logic                          ready;
    logic [tpdg_pkg::ID_W-1:0]     earlier_track;
    logic [tpdg_pkg::ID_W-1:0]     later_track;
    logic [tpdg_pkg::WEIGHT_W-1:0] weight;
    logic                          last_edge;
    logic                          dropped;

    modport source (output valid, earlier_track, later_track, weight, last_edge, dropped,
                    input ready);
    modport sink   (input valid, earlier_track, later_track, weight, last_edge, dropped,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/tpdg_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module tpdg_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    output logic      [WIDTH-1:0]  rdata_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

>>> rtl/tpdg_queue.sv
// Command queue between the point front end and the pair engine.
`default_nettype none
module tpdg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  tpdg_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output tpdg_pkg::cmd_t      pop_cmd,
    output logic                empty
);
    import tpdg_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t            mem_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_reg, rd_reg;
    logic [QC_W-1:0] cnt_reg;
    logic            do_push, do_pop;

    assign full    = cnt_reg == QC_W'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

>>> rtl/tpdg_front.sv
// Front end: gathers points into a free RAM row and classifies finished tracks.
`default_nettype none
module tpdg_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tpdg_point_if.sink                         points,
    output logic                               ram_we,
    output logic [tpdg_pkg::ADDR_W-1:0]        ram_waddr,
    output logic [tpdg_pkg::POINT_W-1:0]       ram_wdata,
    output logic                               q_push,
    output tpdg_pkg::cmd_t                     q_cmd,
    input  wire logic                          q_full,
    input  tpdg_pkg::rel_t                     rel
);
    import tpdg_pkg::*;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ROW_W-1:0]   fill_row_reg;
    logic [ROW_W-1:0]   free_reg [FREE_DEPTH];
    logic [FREE_PW-1:0] free_rd_reg, free_wr_reg;
    logic               acc, has_room, good, take_row;

    assign points.ready = !q_full;
    assign acc          = points.valid && points.ready;
    assign has_room     = count_reg < CNT_W'(TRACK_POINTS);
    assign good         = count_reg == CNT_W'(TRACK_POINTS - 1);

    assign ram_we    = acc && has_room;
    assign ram_waddr = {fill_row_reg, count_reg[IDX_W-1:0]};
    assign ram_wdata = {points.x_coord, points.y_coord};

    assign q_push          = acc && points.last_point;
    assign q_cmd.kind      = good ? CMD_TRACK : CMD_DROP;
    assign q_cmd.end_frame = points.end_frame;
    assign q_cmd.row       = fill_row_reg;
    assign take_row        = q_push && good;

    always_comb
    begin
        count_next = count_reg;
        if (acc)
        begin
            if (points.last_point)
            begin
                count_next = '0;
            end
            else if (has_room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = CNT_W'(CNT_SAT);
            end
        end
    end

    // Free row pool: rows not owned by a slot, the queue or the pair engine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            fill_row_reg <= ROW_W'(WINDOW_TRACKS);
            free_rd_reg  <= '0;
            free_wr_reg  <= FREE_PW'(FREE_DEPTH - 1);
            for (int j = 0; j < FREE_DEPTH; j++)
            begin
                free_reg[j] <= ROW_W'(WINDOW_TRACKS + 1 + j);
            end
        end
        else
        begin
            count_reg <= count_next;
            if (rel.valid)
            begin
                free_reg[free_wr_reg] <= rel.row;
                free_wr_reg           <= free_wr_reg + 1'b1;
            end
            if (take_row)
            begin
                fill_row_reg <= free_reg[free_rd_reg];
                free_rd_reg  <= free_rd_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/tpdg_back.sv
// Pair engine: walks the track window, sums point distances, emits edges.
`default_nettype none
`include "trajectory_pair_distance_graph_defines.svh"
module tpdg_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  tpdg_pkg::cfg_t                     cfg,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    input  tpdg_pkg::cmd_t                     q_cmd,
    output logic [tpdg_pkg::ADDR_W-1:0]        raddr_a,
    output logic [tpdg_pkg::ADDR_W-1:0]        raddr_b,
    input  wire logic [tpdg_pkg::POINT_W-1:0]  rdata_a,
    input  wire logic [tpdg_pkg::POINT_W-1:0]  rdata_b,
    output tpdg_pkg::rel_t                     rel,
    tpdg_edge_if.source                        edges
);
    import tpdg_pkg::*;

    back_state_t state_reg, state_next;

    logic [SLOT_W-1:0]   k_reg, head_reg, slot;
    logic [SLOT_W:0]     slot_sum;
    logic                valid_reg [WINDOW_TRACKS];
    logic [FRAME_W-1:0]  ef_reg    [WINDOW_TRACKS];
    logic [ID_W-1:0]     id_reg    [WINDOW_TRACKS];
    logic [ROW_W-1:0]    map_reg   [WINDOW_TRACKS];
    logic [ID_W-1:0]     next_id_reg;
    logic                dropped_reg, evict_reg;
    logic [FRAME_W-1:0]  nf_reg;
    logic [ROW_W-1:0]    crow_reg, srow_reg, old_row_reg;
    logic [ID_W-1:0]     sid_reg;
    logic [IDX_W-1:0]    off_reg, i_reg, idx_b;
    logic [LIM_W-1:0]    lim_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sxx_reg, syy_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg, rem_sh, trial;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [OG_W-1:0]     og_reg;
    logic [PSQ_W-1:0]    psq_reg;
    logic                pend_valid_reg;
    logic [ID_W-1:0]     pend_earlier_reg, pend_later_reg;
    logic [WEIGHT_W-1:0] pend_weight_reg;
    logic                out_valid_reg, out_last_reg, out_drop_reg;
    logic [ID_W-1:0]     out_earlier_reg, out_later_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;

    logic [FRAME_W-1:0]  s_off;
    logic [OVL_W-1:0]    s_ovl;
    logic                s_valid, s_far, s_take;
    logic [COORD_W-1:0]  dx, dy;
    logic                ge;
    logic [WFULL_W-1:0]  w_full;
    logic [WEIGHT_W-1:0] w_sat;
    logic                out_free, edge_ok, out_load_mid, out_load_last, out_load;
    logic                last_slot, last_point;

    // Slot under test, oldest first.
    assign slot_sum = {1'b0, head_reg} + {1'b0, k_reg};
    assign slot     = (slot_sum >= (SLOT_W+1)'(WINDOW_TRACKS)) ?
                      SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_TRACKS)) : slot_sum[SLOT_W-1:0];

    assign s_valid = valid_reg[slot];
    assign s_off   = nf_reg - ef_reg[slot];
    assign s_far   = s_off > FRAME_W'(TRACK_POINTS);
    assign s_ovl   = OVL_W'(TRACK_POINTS) - s_off[OVL_W-1:0];
    assign s_take  = s_valid && !s_far && (s_ovl > cfg.overlap_threshold);

    assign idx_b   = i_reg - off_reg;
    assign raddr_a = {srow_reg, i_reg};
    assign raddr_b = {crow_reg, idx_b};

    assign dx = (rdata_a[POINT_W-1:COORD_W] > rdata_b[POINT_W-1:COORD_W]) ?
                rdata_a[POINT_W-1:COORD_W] - rdata_b[POINT_W-1:COORD_W] :
                rdata_b[POINT_W-1:COORD_W] - rdata_a[POINT_W-1:COORD_W];
    assign dy = (rdata_a[COORD_W-1:0] > rdata_b[COORD_W-1:0]) ?
                rdata_a[COORD_W-1:0] - rdata_b[COORD_W-1:0] :
                rdata_b[COORD_W-1:0] - rdata_a[COORD_W-1:0];

    // Restoring square root, one result bit per cycle.
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    // Penalty (offset*gamma)^2 rounded from Q.16 to Q.4.
    assign w_full = WFULL_W'(sum_reg) +
                    WFULL_W'((WFULL_W'(psq_reg) + WFULL_W'(PEN_ROUND)) >> PEN_SHIFT);
    assign w_sat  = (|w_full[WFULL_W-1:WEIGHT_W]) ? '1 : w_full[WEIGHT_W-1:0];

    assign last_slot  = k_reg == SLOT_W'(WINDOW_TRACKS - 1);
    assign last_point = i_reg == IDX_W'(TRACK_POINTS - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty && q_cmd.kind == CMD_TRACK) state_next = B_SLOT;
            B_SLOT: state_next = s_take ? B_RD : B_NEXT;
            B_RD:   state_next = B_SQ;
            B_SQ:   state_next = B_INIT;
            B_INIT: state_next = B_ROOT;
            B_ROOT: if (step_reg == STEP_W'(ROOT_STEPS - 1)) state_next = B_ACC;
            B_ACC:  state_next = last_point ? B_CMP : B_RD;
            B_CMP:  state_next = (sum_reg < SUM_W'(lim_reg)) ? B_PEN : B_NEXT;
            B_PEN:  state_next = B_EDGE;
            B_EDGE: if (edge_ok) state_next = B_NEXT;
            B_NEXT: state_next = last_slot ? B_FIN : B_SLOT;
            B_FIN:  state_next = pend_valid_reg ? B_LAST : B_IDLE;
            B_LAST: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        out_free      = !out_valid_reg || edges.ready;
        q_pop         = (state_reg == B_IDLE) && !q_empty;
        edge_ok       = (state_reg == B_EDGE) && (!pend_valid_reg || out_free);
        out_load_mid  = (state_reg == B_EDGE) && pend_valid_reg && out_free;
        out_load_last = (state_reg == B_LAST) && out_free;
        out_load      = out_load_mid || out_load_last;
        rel.valid     = state_reg == B_FIN;
        rel.row       = old_row_reg;
    end

    assign edges.valid         = out_valid_reg;
    assign edges.earlier_track = out_earlier_reg;
    assign edges.later_track   = out_later_reg;
    assign edges.weight        = out_weight_reg;
    assign edges.last_edge     = out_last_reg;
    assign edges.dropped       = out_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            k_reg          <= '0;
            head_reg       <= '0;
            next_id_reg    <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int s = 0; s < WINDOW_TRACKS; s++)
            begin
                valid_reg[s] <= 1'b0;
                map_reg[s]   <= ROW_W'(s);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                if (q_cmd.kind == CMD_DROP)
                begin
                    dropped_reg <= 1'b1;
                end
                k_reg <= '0;
            end
            if (state_reg == B_SLOT && s_valid && s_far)
            begin
                valid_reg[slot] <= 1'b0;
            end
            if (state_reg == B_NEXT && !last_slot)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == B_FIN)
            begin
                valid_reg[head_reg] <= 1'b1;
                map_reg[head_reg]   <= crow_reg;
                next_id_reg         <= next_id_reg + 1'b1;
                head_reg            <= (head_reg == SLOT_W'(WINDOW_TRACKS - 1)) ?
                                       '0 : head_reg + 1'b1;
                dropped_reg         <= dropped_reg || evict_reg;
            end
            if (edge_ok)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_load_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (edges.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            nf_reg   <= q_cmd.end_frame;
            crow_reg <= q_cmd.row;
        end
        if (state_reg == B_SLOT)
        begin
            if (k_reg == '0)
            begin
                // Head slot gets overwritten at the end; note an early eviction.
                evict_reg   <= s_valid && !s_far;
                old_row_reg <= map_reg[slot];
            end
            if (s_take)
            begin
                off_reg  <= s_off[IDX_W-1:0];
                i_reg    <= s_off[IDX_W-1:0];
                sum_reg  <= '0;
                lim_reg  <= LIM_W'(cfg.spatial_threshold) * LIM_W'(s_ovl);
                srow_reg <= map_reg[slot];
                sid_reg  <= id_reg[slot];
            end
        end
        if (state_reg == B_SQ)
        begin
            sxx_reg <= dx * dx;
            syy_reg <= dy * dy;
        end
        if (state_reg == B_INIT)
        begin
            rad_reg  <= RAD_W'(sxx_reg) + RAD_W'(syy_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        if (state_reg == B_ROOT)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == B_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(root_reg);
            if (!last_point)
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
        if (state_reg == B_CMP)
        begin
            og_reg <= off_reg * cfg.gamma;
        end
        if (state_reg == B_PEN)
        begin
            psq_reg <= og_reg * og_reg;
        end
        if (edge_ok)
        begin
            pend_earlier_reg <= sid_reg;
            pend_later_reg   <= next_id_reg;
            pend_weight_reg  <= w_sat;
        end
        if (out_load)
        begin
            out_earlier_reg <= pend_earlier_reg;
            out_later_reg   <= pend_later_reg;
            out_weight_reg  <= pend_weight_reg;
            out_last_reg    <= out_load_last;
            out_drop_reg    <= dropped_reg || evict_reg;
        end
        if (state_reg == B_FIN)
        begin
            ef_reg[head_reg] <= nf_reg;
            id_reg[head_reg] <= next_id_reg;
        end
    end

    `TPDG_ASSERT_IMP(a_idle_no_pend, state_reg == B_IDLE, !pend_valid_reg, "edge left pending at idle")
    `TPDG_ASSERT_NEXT(a_sq_after_rd, state_reg == B_RD, state_reg == B_SQ, "RAM read not followed by square")
    `TPDG_ASSERT_IMP(a_root_bound, state_reg == B_ROOT, step_reg < STEP_W'(ROOT_STEPS), "root step overrun")
endmodule
`default_nettype wire

>>> rtl/trajectory_pair_distance_graph.sv
// Top level of the trajectory pair distance graph.
// Use:
//  points: one item per track point (end_frame, x_coord, y_coord, last_point).
//    Every track has exactly TRACK_POINTS points; tracks arrive sorted by end frame.
//  edges: one item per qualifying pair of the finished track with a stored
//    earlier track, oldest stored track first; last_edge marks the final one,
//    dropped carries the sticky drop flag as it stands after that track.
//  cfg_we/cfg_index/cfg_data: write gamma, spatial_threshold, overlap_threshold
//    while the block is idle.
// Throughput: a point item is taken every cycle while the command queue has room.
//  A finished track occupies the pair engine while it walks every window slot; for
//  each overlapping point it reads both rows, squares the differences, runs the
//  square-root loop (one square-root bit per cycle, 17 bits) and adds the root;
//  each compared pair then checks its sum against the limit. The root loop dominates.
//  Up to two finished tracks queue up while points of the next keep arriving.
// Output: an edge is held pending until the walk reaches the next edge or ends.
// Reset clears the window, counters and drop flag; configuration returns to
//  gamma 256, spatial_threshold 256, overlap_threshold 8.
// A stalled edges receiver holds the engine once its output and pending edge fill.
`default_nettype none
module trajectory_pair_distance_graph (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tpdg_point_if.sink                             points,
    tpdg_edge_if.source                            edges,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [tpdg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tpdg_pkg::*;

    logic [GAMMA_W-1:0] gamma_reg;
    logic [THR_W-1:0]   spatial_reg;
    logic [OVL_W-1:0]   overlap_reg;
    cfg_t               cfg;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, raddr_a, raddr_b;
    logic [POINT_W-1:0] ram_wdata, rdata_a, rdata_b;
    logic               q_push, q_full, q_pop, q_empty;
    cmd_t               push_cmd, pop_cmd;
    rel_t               rel;

    // Configuration registers; index 3 is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg   <= GAMMA_W'(256);
            spatial_reg <= THR_W'(256);
            overlap_reg <= OVL_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAMMA:   gamma_reg   <= cfg_data[GAMMA_W-1:0];
                CFG_SPATIAL: spatial_reg <= cfg_data[THR_W-1:0];
                CFG_OVERLAP: overlap_reg <= cfg_data[OVL_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg.gamma             = gamma_reg;
    assign cfg.spatial_threshold = spatial_reg;
    assign cfg.overlap_threshold = overlap_reg;

    // Point rows: one per window slot plus spares for tracks in flight.
    tpdg_ram #(
        .WIDTH (POINT_W),
        .DEPTH (RAM_DEPTH)
    ) u_points (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    tpdg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .q_full    (q_full),
        .rel       (rel)
    );

    tpdg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tpdg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_cmd   (pop_cmd),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .rel     (rel),
        .edges   (edges)
    );
endmodule
`default_nettype wire

>>> dv/trajectory_pair_distance_graph_tb.sv
// Self-checking testbench of the trajectory pair distance graph: directed tracks, then random.
`default_nettype none
module trajectory_pair_distance_graph_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpdg_pkg::*;

    // Idle time after the last edge: one track in the engine and two queued,
    // each walking a full window of 15-point square-root pairs, plus margin.
    localparam int DRAIN_CYCLES = 40000;
    localparam int HOLD_CYCLES  = 5000;

    typedef enum int { TK_NORMAL, TK_SHORT, TK_LONG, TK_EXTREME, TK_WILD } track_kind_t;

    typedef struct {
        logic [ID_W-1:0]     earlier;
        logic [ID_W-1:0]     later;
        logic [WEIGHT_W-1:0] weight;
        logic                last_edge;
        logic                dropped;
    } edge_rec_t;

    typedef struct {
        track_kind_t        kind;
        logic [FRAME_W-1:0] frame;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        int                 noise;
        bit                 typed;
        edge_rec_t          want;
    } track_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tpdg_point_if pts();
    tpdg_edge_if  eg();

    trajectory_pair_distance_graph u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (pts),
        .edges     (eg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------- graph predictor ----------------
    logic [GAMMA_W-1:0]  g_gamma;
    logic [THR_W-1:0]    g_thr;
    logic [OVL_W-1:0]    g_ovl;
    logic [POINT_W-1:0]  g_pts [WINDOW_TRACKS][TRACK_POINTS];
    logic [FRAME_W-1:0]  g_frame [WINDOW_TRACKS];
    logic [ID_W-1:0]     g_id [WINDOW_TRACKS];
    logic [WINDOW_TRACKS-1:0] g_valid;
    int                  g_head;
    int                  g_cnt;
    logic [ID_W-1:0]     g_next_id;
    logic                g_drop;
    logic [POINT_W-1:0]  g_cur [TRACK_POINTS];

    edge_rec_t pending_edges[$];
    int        errors;

    function automatic logic [63:0] isqrt(input logic [63:0] v0);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v0;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] adiff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? 64'(a - b) : 64'(b - a);
    endfunction

    // Advances the graph state by one accepted point, queuing the edges it causes.
    task automatic graph_point(input logic [15:0] ef, input logic [15:0] x,
                               input logic [15:0] y, input logic lastp);
        edge_rec_t found [$];
        edge_rec_t e;
        int s;
        int off;
        int ovl;
        logic [63:0] sum;
        logic [63:0] og;
        logic [63:0] w;
        logic [POINT_W-1:0] p;
        logic [POINT_W-1:0] q;
        logic [63:0] dx;
        logic [63:0] dy;
        if (g_cnt < TRACK_POINTS)
        begin
            g_cur[g_cnt] = {x, y};
            g_cnt++;
        end
        else
            g_cnt = CNT_SAT;
        if (!lastp)
            return;
        if (g_cnt != TRACK_POINTS)
        begin
            // malformed track: discarded, no index
            g_drop = 1'b1;
            g_cnt = 0;
            return;
        end
        g_cnt = 0;
        for (int k = 0; k < WINDOW_TRACKS; k++)
        begin
            s = (g_head + k) % WINDOW_TRACKS;
            if (!g_valid[s])
                continue;
            off = int'(16'(ef - g_frame[s]));
            if (off > TRACK_POINTS)
            begin
                g_valid[s] = 1'b0;  // aged out, not a drop
                continue;
            end
            ovl = TRACK_POINTS - off;
            if (ovl <= g_ovl)
                continue;
            sum = 0;
            for (int i = off; i < TRACK_POINTS; i++)
            begin
                p = g_pts[s][i];
                q = g_cur[i - off];
                dx = adiff(p[31:16], q[31:16]);
                dy = adiff(p[15:0], q[15:0]);
                sum += isqrt(dx * dx + dy * dy);
            end
            if (sum < 64'(g_thr) * 64'(ovl))
            begin
                if (found.size() < 32)
                begin
                    og = 64'(off) * 64'(g_gamma);
                    w = sum + ((og * og + PEN_ROUND) >> PEN_SHIFT);
                    if (w > 64'hFFFF_FFFF)
                        w = 64'hFFFF_FFFF;
                    e.earlier = g_id[s];
                    e.later = g_next_id;
                    e.weight = w[31:0];
                    e.last_edge = 1'b0;
                    e.dropped = 1'b0;
                    found = {found, e};
                end
                else
                    g_drop = 1'b1;
            end
        end
        s = g_head;
        // early eviction of a track still inside the frame window
        if (g_valid[s] && int'(16'(ef - g_frame[s])) <= TRACK_POINTS)
            g_drop = 1'b1;
        for (int i = 0; i < TRACK_POINTS; i++)
            g_pts[s][i] = g_cur[i];
        g_frame[s] = ef;
        g_id[s] = g_next_id;
        g_valid[s] = 1'b1;
        g_next_id = g_next_id + 1'b1;
        g_head = (s + 1) % WINDOW_TRACKS;
        foreach (found[j])
        begin
            found[j].dropped = g_drop;
            found[j].last_edge = (j == found.size() - 1);
            pending_edges = {pending_edges, found[j]};
        end
    endtask

    // ---------------- edge checker ----------------
    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        edge_rec_t w;
        if (rst_n && eg.valid && eg.ready)
        begin
            if (pending_edges.size() == 0)
                report($sformatf("unexpected edge %0d->%0d", eg.earlier_track,
                                 eg.later_track));
            else
            begin
                w = pending_edges.pop_front();
                if (eg.earlier_track !== w.earlier)
                    report($sformatf("earlier_track %0d, want %0d", eg.earlier_track,
                                     w.earlier));
                if (eg.later_track !== w.later)
                    report($sformatf("later_track %0d, want %0d", eg.later_track, w.later));
                if (eg.weight !== w.weight)
                    report($sformatf("weight %0d, want %0d", eg.weight, w.weight));
                if (eg.last_edge !== w.last_edge)
                    report($sformatf("last_edge %b, want %b", eg.last_edge, w.last_edge));
                if (eg.dropped !== w.dropped)
                    report($sformatf("dropped %b, want %b", eg.dropped, w.dropped));
            end
        end
    end

    // ---------------- edge receiver ----------------
    // Stalls on its own pattern; one long hold-off on request from the sender.
    bit hold_req;
    int hold_left;
    int mode;
    int mode_left;

    always @(posedge clk)
    begin
        if (!rst_n)
            eg.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            eg.ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            eg.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (mode)
                0: eg.ready <= 1'b1;
                1: eg.ready <= ($urandom_range(0, 1) == 0);
                2: eg.ready <= ($urandom_range(0, 9) == 0);
                default: eg.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------- point sender ----------------
    int burst_left;

    task automatic send_point(input logic [15:0] ef, input logic [15:0] x,
                              input logic [15:0] y, input logic lastp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                pts.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pts.valid <= 1'b1;
        pts.end_frame <= ef;
        pts.x_coord <= x;
        pts.y_coord <= y;
        pts.last_point <= lastp;
        do
            @(posedge clk);
        while (!pts.ready);
        graph_point(ef, x, y, lastp);
    endtask

    task automatic send_track(input track_kind_t kind, input logic [15:0] ef,
                              input logic [15:0] bx, input logic [15:0] by,
                              input int noise);
        int npts;
        logic [15:0] x;
        logic [15:0] y;
        npts = (kind == TK_SHORT) ? $urandom_range(1, TRACK_POINTS - 1) :
               (kind == TK_LONG) ? $urandom_range(TRACK_POINTS + 1, TRACK_POINTS + 6) :
               TRACK_POINTS;
        for (int i = 0; i < npts; i++)
        begin
            case (kind)
                TK_EXTREME:
                begin
                    x = i[0] ? 16'hFFFF : 16'h0000;
                    y = i[1] ? 16'hFFFF : 16'h0000;
                end
                TK_WILD:
                begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                default:
                begin
                    x = bx + 16'($urandom_range(0, noise));
                    y = by + 16'($urandom_range(0, noise));
                end
            endcase
            send_point(ef, x, y, i == npts - 1);
        end
    endtask

    // Pause input until every edge is out and the engine has had time to finish.
    task automatic settle();
        pts.valid <= 1'b0;
        @(posedge clk);
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GAMMA:   g_gamma = val;
            CFG_SPATIAL: g_thr = val;
            default:     g_ovl = val[OVL_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic [15:0] gm, input logic [15:0] thr,
                              input logic [4:0] ovl);
        settle();
        write_reg(CFG_GAMMA, gm);
        write_reg(CFG_SPATIAL, thr);
        write_reg(CFG_OVERLAP, 16'(ovl));
    endtask

    // Random tracks in a cluster, mostly sorted frames with small steps;
    // some malformed, some scattered, rare frame jumps.
    task automatic random_tracks(input int count, inout logic [15:0] ef, input int hold_at);
        logic [15:0] bx;
        logic [15:0] by;
        int pick;
        int step;
        bx = 16'($urandom);
        by = 16'($urandom);
        for (int t = 0; t < count; t++)
        begin
            if (t == hold_at)
                hold_req = 1'b1;
            step = $urandom_range(0, 99);
            if (step >= 97)
                ef = 16'($urandom);
            else if (step >= 80)
                ef = ef + 16'($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            send_track(pick < 8 ? TK_SHORT : pick < 16 ? TK_LONG :
                       pick < 26 ? TK_WILD : TK_NORMAL,
                       ef, bx, by, $urandom_range(0, 96));
        end
    endtask

    track_row_t rows [10];

    initial
    begin
        logic [15:0] ef;
        int before_n;
        // power-on values
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_GAMMA;
        cfg_data <= '0;
        pts.valid <= 1'b0;
        pts.end_frame <= '0;
        pts.x_coord <= '0;
        pts.y_coord <= '0;
        pts.last_point <= 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        errors = 0;
        burst_left = 0;
        g_gamma = 256;
        g_thr = 256;
        g_ovl = 8;
        g_valid = '0;
        g_head = 0;
        g_cnt = 0;
        g_next_id = '0;
        g_drop = 1'b0;

        // Directed tracks at reset configuration. Only the plain repeat of the
        // first track has an edge that is obvious by eye: zero distance, offset 0.
        rows[0] = '{TK_NORMAL, 16'd100, 16'd1000, 16'd1000, 0, 0, '{0, 0, 0, 0, 0}};
        rows[1] = '{TK_NORMAL, 16'd100, 16'd1000, 16'd1000, 0, 1, '{0, 1, 0, 1, 0}};
        rows[2] = '{TK_SHORT, 16'd100, 16'd1000, 16'd1000, 0, 0, '{0, 0, 0, 0, 0}};
        rows[3] = '{TK_LONG, 16'd100, 16'd1000, 16'd1000, 0, 0, '{0, 0, 0, 0, 0}};
        // offset 5 against both stored tracks: penalty only
        rows[4] = '{TK_NORMAL, 16'd105, 16'd1000, 16'd1000, 0, 0, '{0, 0, 0, 0, 0}};
        rows[5] = '{TK_EXTREME, 16'd105, 16'd0, 16'd0, 0, 0, '{0, 0, 0, 0, 0}};
        rows[6] = '{TK_EXTREME, 16'd105, 16'd0, 16'd0, 0, 0, '{0, 0, 0, 0, 0}};
        // far jump ages out the whole window, then the frame wraps past zero
        rows[7] = '{TK_NORMAL, 16'hFFFF, 16'hFFF0, 16'h0000, 15, 0, '{0, 0, 0, 0, 0}};
        rows[8] = '{TK_NORMAL, 16'h0003, 16'hFFF0, 16'h0000, 15, 0, '{0, 0, 0, 0, 0}};
        rows[9] = '{TK_WILD, 16'h0003, 16'd0, 16'd0, 0, 0, '{0, 0, 0, 0, 0}};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            before_n = pending_edges.size();
            send_track(rows[r].kind, rows[r].frame, rows[r].bx, rows[r].by, rows[r].noise);
            if (rows[r].typed)
            begin
                while (pending_edges.size() > before_n)
                    void'(pending_edges.pop_back());
                pending_edges = {pending_edges, rows[r].want};
            end
        end

        // Extreme settings: lowest overlap threshold, highest spatial threshold, heaviest penalty.
        ef = 16'h0003;
        set_config(16'hFFFF, 16'hFFFF, 5'd0);
        random_tracks(2, ef, -1);
        // Nothing can qualify.
        set_config(16'h0000, 16'h0000, 5'd31);
        random_tracks(1, ef, -1);
        // Mid settings, mostly sorted frames, and one long receiver hold-off while
        // points keep coming.
        set_config(16'($urandom_range(1, 1024)), 16'($urandom_range(512, 8000)),
                   5'($urandom_range(0, 10)));
        random_tracks(8, ef, 2);

        settle();
        if (errors == 0 && pending_edges.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
